@@ rtl/core/mfm_pkg.sv @@
// shared types and constants for the mains frequency meter
package mfm_pkg;

   // field widths
   localparam int PERIOD_W = 16;
   localparam int FREQ_W   = 27;
   localparam int HZ_W     = 24;

   // defaults for the top level parameters
   localparam int DEF_WINDOW_LEN  = 16;
   localparam int DEF_QUEUE_DEPTH = 2;

   // tick frequency after reset
   localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(1000000);

   // saturated frequency code
   localparam logic [HZ_W-1:0] HZ_MAX = {HZ_W{1'b1}};

   // 256 / 2 scaling of the frequency numerator, as a shift
   localparam int HZ_SCALE_SHIFT = 7;

   // shared divider widths
   localparam int DIV_NUM_W = FREQ_W + HZ_SCALE_SHIFT;
   localparam int DIV_DEN_W = PERIOD_W;

   // divider status toward its user
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_AVG,
      BK_FREQ,
      BK_DONE
   } back_state_type;

endpackage

@@ rtl/core/mfm_front.sv @@
// front end: arming, window count and period sum, hands finished sums on
module mfm_front
   import mfm_pkg::*;
#(
   parameter int WINDOW_LEN = DEF_WINDOW_LEN,
   parameter int SUM_W      = PERIOD_W + $clog2(WINDOW_LEN)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [PERIOD_W-1:0] req_period_ticks,
   input  logic                q_full,
   output logic                q_push,
   output logic [SUM_W-1:0]    q_data
);

   localparam int CNT_W = $clog2(WINDOW_LEN);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_LEN - 1);

   logic             armed_ff, armed_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0] sum_next;

   // running sum including the current period
   assign sum_next = sum_ff + SUM_W'(req_period_ticks);

   // window bookkeeping
   always_comb begin
      armed_in = armed_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      q_push   = 1'b0;
      if (req_valid) begin
         if (!armed_ff) begin
            armed_in = 1'b1;
         end else if (count_ff == CNT_LAST) begin
            q_push   = 1'b1;
            count_in = '0;
            sum_in   = '0;
         end else begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_next;
         end
      end
   end

   assign q_data = sum_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         armed_ff <= armed_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // a finished window never meets a full queue
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("window sum pushed into a full queue");

   // nothing is summed before the first edge arms the block
   a_idle_until_armed: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> (count_ff == '0 && sum_ff == '0))
      else $error("window state moved before arming");

endmodule

@@ rtl/core/mfm_queue.sv @@
// short register queue between the front and back ends
module mfm_queue #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

@@ rtl/core/mfm_div.sv @@
// restoring divider, one quotient bit per cycle
module mfm_div
   import mfm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic [DIV_NUM_W-1:0] quo,
   output div_status_type       status
);

   localparam int STEP_W = $clog2(DIV_NUM_W + 1);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_NUM_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   diff;

   // trial subtraction of one step
   assign shifted = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (!diff[DIV_DEN_W]) begin
            rem_in = diff[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quo         = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   // done only follows the last step of a running division
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("divider done without a finished division");

endmodule

@@ rtl/core/mfm_back.sv @@
// back end: averages a window sum and converts it to a frequency
module mfm_back
   import mfm_pkg::*;
#(
   parameter int WINDOW_LEN = DEF_WINDOW_LEN,
   parameter int SUM_W      = PERIOD_W + $clog2(WINDOW_LEN)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  logic [SUM_W-1:0]    q_data,
   output logic                q_pop,
   input  logic [FREQ_W-1:0]   tick_freq_hz,
   output logic                rsp_valid,
   input  logic                rsp_pop,
   output logic [PERIOD_W-1:0] rsp_avg_period_ticks,
   output logic [HZ_W-1:0]     rsp_mains_hz_q8,
   output logic                rsp_freq_invalid
);

   // exact floor(sum / WINDOW_LEN) as a multiply by a rounded-up reciprocal
   localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW_LEN);
   localparam int RECIP_W   = SUM_W + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam logic [63:0] AVG_RECIP_FULL =
      ((64'd1 << AVG_SHIFT) + 64'(WINDOW_LEN - 1)) / 64'(WINDOW_LEN);
   localparam logic [RECIP_W-1:0] AVG_RECIP = AVG_RECIP_FULL[RECIP_W-1:0];

   back_state_type       state_ff, state_in;
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] div_quo;
   div_status_type       div_status;
   logic [PROD_W-1:0]    avg_prod;
   logic [PERIOD_W-1:0]  avg_calc;
   logic [PERIOD_W-1:0]  avg_ff, avg_in;
   logic [HZ_W-1:0]      hz_ff, hz_in;
   logic                 inv_ff, inv_in;
   logic                 out_load;
   logic                 out_valid_ff, out_valid_in;
   logic [PERIOD_W-1:0]  out_avg_ff;
   logic [HZ_W-1:0]      out_hz_ff;
   logic                 out_inv_ff;

   mfm_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .quo    (div_quo),
      .status (div_status)
   );

   // window average, 20 by 21 bits at the default window
   assign avg_prod = PROD_W'(q_data) * PROD_W'(AVG_RECIP);
   assign avg_calc = avg_prod[AVG_SHIFT +: PERIOD_W];

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer: average, then frequency, then hand to the output register
   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      avg_in    = avg_ff;
      hz_in     = hz_ff;
      inv_in    = inv_ff;
      out_load  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               avg_in   = avg_calc;
               state_in = BK_AVG;
            end
         end
         BK_AVG: begin
            if (avg_ff == '0) begin
               hz_in    = HZ_MAX;
               inv_in   = 1'b1;
               state_in = BK_DONE;
            end else begin
               div_start = 1'b1;
               div_num   = {tick_freq_hz, HZ_SCALE_SHIFT'(0)};
               div_den   = avg_ff;
               state_in  = BK_FREQ;
            end
         end
         BK_FREQ: begin
            if (div_status.done) begin
               if (div_quo[DIV_NUM_W-1:HZ_W] != '0) begin
                  hz_in  = HZ_MAX;
                  inv_in = 1'b1;
               end else begin
                  hz_in  = div_quo[HZ_W-1:0];
                  inv_in = 1'b0;
               end
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      avg_ff <= avg_in;
      hz_ff  <= hz_in;
      inv_ff <= inv_in;
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_avg_ff <= avg_ff;
         out_hz_ff  <= hz_ff;
         out_inv_ff <= inv_ff;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_avg_period_ticks = out_avg_ff;
   assign rsp_mains_hz_q8      = out_hz_ff;
   assign rsp_freq_invalid     = out_inv_ff;

   // divider results only arrive while a division is expected
   a_done_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == BK_AVG || state_ff == BK_FREQ))
      else $error("divider finished outside a division state");

   // a zero average always comes out flagged and saturated
   a_zero_avg_flagged: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_avg_ff == '0) |-> (out_inv_ff && out_hz_ff == HZ_MAX))
      else $error("zero average without saturated invalid frequency");

endmodule

@@ rtl/core/mains_frequency_meter_core.sv @@
// mains frequency meter top level: csr register, front end, queue and back end
// a request is taken in its push cycle, back to back while the window-sum queue has room
// a result follows its window's last request via the queue, a reciprocal-multiply average,
//   one divider run for the frequency and sequencing; a zero average skips the divider run
// one window sum at a time in the back end; full while two window sums wait in the queue
// synchronous active-high reset clears control state, sets tick frequency to 1000000 Hz
module mains_frequency_meter_core
   import mfm_pkg::*;
#(
   parameter int WINDOW_LEN  = DEF_WINDOW_LEN,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [PERIOD_W-1:0] req_period_ticks,
   output logic                empty,
   input  logic                pop,
   output logic [PERIOD_W-1:0] rsp_avg_period_ticks,
   output logic [HZ_W-1:0]     rsp_mains_hz_q8,
   output logic                rsp_freq_invalid,
   input  logic                csr_wr_en,
   input  logic [FREQ_W-1:0]   csr_wr_data
);

   localparam int SUM_W = PERIOD_W + $clog2(WINDOW_LEN);

   logic [FREQ_W-1:0] tick_freq_ff;
   logic              q_push, q_pop, q_full, q_empty;
   logic [SUM_W-1:0]  q_din, q_dout;
   logic              rsp_valid;
   logic              req_valid;

   // tick frequency register
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_freq_ff <= FREQ_RESET;
      end else if (csr_wr_en) begin
         tick_freq_ff <= csr_wr_data;
      end
   end

   assign full      = q_full;
   assign req_valid = push && !q_full;
   assign empty     = !rsp_valid;

   mfm_front #(
      .WINDOW_LEN (WINDOW_LEN),
      .SUM_W      (SUM_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_period_ticks (req_period_ticks),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_din)
   );

   mfm_queue #(
      .WIDTH (SUM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .full  (q_full),
      .empty (q_empty)
   );

   mfm_back #(
      .WINDOW_LEN (WINDOW_LEN),
      .SUM_W      (SUM_W)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (q_empty),
      .q_data               (q_dout),
      .q_pop                (q_pop),
      .tick_freq_hz         (tick_freq_ff),
      .rsp_valid            (rsp_valid),
      .rsp_pop              (pop),
      .rsp_avg_period_ticks (rsp_avg_period_ticks),
      .rsp_mains_hz_q8      (rsp_mains_hz_q8),
      .rsp_freq_invalid     (rsp_freq_invalid)
   );

endmodule

@@ test/tb_mains_frequency_meter_core.sv @@
// testbench for the mains frequency meter core: zero-cross windows checked against a predictor
module tb_mains_frequency_meter_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mfm_pkg::*;

   localparam int WINDOW        = DEF_WINDOW_LEN;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES   = 1500;
   localparam int PHASE_ITEMS   = 64;
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [FREQ_W-1:0] FREQ_TOP = FREQ_W'(100000000);

   typedef struct packed {
      logic [PERIOD_W-1:0] avg;
      logic [HZ_W-1:0]     hz;
      logic                invalid;
   } meter_reading_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push = 1'b0;
   logic                full;
   logic [PERIOD_W-1:0] req_period_ticks = '0;
   logic                empty;
   logic                pop = 1'b0;
   logic [PERIOD_W-1:0] rsp_avg_period_ticks;
   logic [HZ_W-1:0]     rsp_mains_hz_q8;
   logic                rsp_freq_invalid;
   logic                csr_wr_en = 1'b0;
   logic [FREQ_W-1:0]   csr_wr_data = '0;

   // predictor state and configuration copy
   bit                  meter_armed = 1'b0;
   int                  window_count = 0;
   logic [31:0]         window_sum = '0;
   logic [FREQ_W-1:0]   tick_freq_mirror = FREQ_RESET;
   meter_reading_type   expected_readings[$];

   int                  mismatch_count = 0;
   int                  sender_idle_pct = 0;
   int                  receiver_stall_pct = 0;
   logic                hold_active = 1'b0;
   int                  cycle_count = 0;

   mains_frequency_meter_core uut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_period_ticks    (req_period_ticks),
      .empty               (empty),
      .pop                 (pop),
      .rsp_avg_period_ticks(rsp_avg_period_ticks),
      .rsp_mains_hz_q8     (rsp_mains_hz_q8),
      .rsp_freq_invalid    (rsp_freq_invalid),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_mains_frequency_meter_core: FAIL");
         $finish;
      end
   end

   // one zero-cross edge: arm, accumulate, and emit a reading at the end of a window
   function automatic void predict_zero_cross(input logic [PERIOD_W-1:0] period);
      meter_reading_type reading;
      logic [63:0]       mean;
      logic [63:0]       quotient;
      if (!meter_armed) begin
         meter_armed = 1'b1;
      end else begin
         window_sum += 32'(period);
         window_count++;
         if (window_count == WINDOW) begin
            mean = 64'(window_sum) / 64'(WINDOW);
            window_sum = '0;
            window_count = 0;
            reading.avg = mean[PERIOD_W-1:0];
            reading.invalid = 1'b0;
            if (mean == 0) begin
               reading.hz = HZ_MAX;
               reading.invalid = 1'b1;
            end else begin
               quotient = (64'(tick_freq_mirror) << HZ_SCALE_SHIFT) / mean;
               if (quotient > 64'(HZ_MAX)) begin
                  reading.hz = HZ_MAX;
                  reading.invalid = 1'b1;
               end else begin
                  reading.hz = quotient[HZ_W-1:0];
               end
            end
            expected_readings.push_back(reading);
         end
      end
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= !hold_active && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      meter_reading_type want;
      if (!reset && pop && !empty) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected result, actual avg %0d hz %0d invalid %0d", $time,
                     rsp_avg_period_ticks, rsp_mains_hz_q8, rsp_freq_invalid);
            mismatch_count++;
         end else begin
            want = expected_readings.pop_front();
            compare_field("avg_period_ticks", 32'(want.avg), 32'(rsp_avg_period_ticks));
            compare_field("mains_hz_q8", 32'(want.hz), 32'(rsp_mains_hz_q8));
            compare_field("freq_invalid", 32'(want.invalid), 32'(rsp_freq_invalid));
         end
      end
   end

   // one request: random idle gap, then hold push until accepted
   task automatic send_period(input logic [PERIOD_W-1:0] period);
      while ($urandom_range(99) < sender_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_period_ticks <= period;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_zero_cross(period);
   endtask

   // drop push, wait for all readings, then let the back end settle
   task automatic wait_for_idle();
      push <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tick_freq(input logic [FREQ_W-1:0] freq);
      csr_wr_en <= 1'b1;
      csr_wr_data <= freq;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tick_freq_mirror = freq;
      @(posedge clock);
   endtask

   // windows of mains-like, uniform, tiny and near-maximum periods
   task automatic send_random_periods(input int count);
      int                  kind;
      int                  center;
      logic [PERIOD_W-1:0] period;
      kind = 0;
      center = 1000;
      for (int i = 0; i < count; i++) begin
         if (i % WINDOW == 0) begin
            kind = $urandom_range(9);
            center = $urandom_range(60000, 100);
         end
         if (kind < 5) begin
            period = PERIOD_W'(center + $urandom_range(64));
         end else if (kind < 7) begin
            period = PERIOD_W'($urandom_range(65535));
         end else if (kind < 9) begin
            period = PERIOD_W'($urandom_range(2));
         end else begin
            period = PERIOD_W'($urandom_range(65535, 65500));
         end
         send_period(period);
      end
   endtask

   // arming edge, then a window of alternating all-zero and all-one periods
   task automatic test_extreme_periods();
      send_period('1);
      for (int i = 0; i < WINDOW; i++) begin
         send_period((i % 2) ? '1 : '0);
      end
      wait_for_idle();
   endtask

   // zero average, frequency overflow, and zero tick frequency
   task automatic test_special_cases();
      for (int i = 0; i < WINDOW - 1; i++) begin
         send_period(PERIOD_W'($urandom_range(1)));
      end
      send_period('0);
      wait_for_idle();
      write_tick_freq(FREQ_TOP);
      for (int i = 0; i < WINDOW; i++) begin
         send_period(PERIOD_W'($urandom_range(3, 1)));
      end
      wait_for_idle();
      write_tick_freq('0);
      for (int i = 0; i < WINDOW; i++) begin
         send_period(PERIOD_W'($urandom_range(65535)));
      end
      for (int i = 0; i < WINDOW; i++) begin
         send_period('0);
      end
      wait_for_idle();
   endtask

   // random windows under each idle pattern and tick frequency setting
   task automatic test_idle_phases();
      write_tick_freq(FREQ_W'(1));
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_random_periods(PHASE_ITEMS);
      wait_for_idle();

      write_tick_freq('1);
      sender_idle_pct = 53;
      receiver_stall_pct = 0;
      send_random_periods(PHASE_ITEMS);
      wait_for_idle();

      write_tick_freq(FREQ_W'($urandom_range(100000000, 1)));
      sender_idle_pct = 0;
      receiver_stall_pct = 53;
      send_random_periods(PHASE_ITEMS);
      wait_for_idle();

      write_tick_freq(FREQ_RESET);
      sender_idle_pct = 36;
      receiver_stall_pct = 36;
      send_random_periods(PHASE_ITEMS);
      wait_for_idle();
   endtask

   // receiver holds off while the sender keeps pushing, so the queue fills
   task automatic test_backpressure();
      write_tick_freq(FREQ_W'($urandom_range(134217727)));
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      fork
         begin
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active <= 1'b0;
         end
      join_none
      send_random_periods(6 * WINDOW);
      wait_for_idle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extreme_periods();
      test_special_cases();
      test_idle_phases();
      test_backpressure();
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("tb_mains_frequency_meter_core: PASS");
      end else begin
         $display("tb_mains_frequency_meter_core: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/mfm_pkg.sv
rtl/core/mfm_front.sv
rtl/core/mfm_queue.sv
rtl/core/mfm_div.sv
rtl/core/mfm_back.sv
rtl/core/mains_frequency_meter_core.sv
test/tb_mains_frequency_meter_core.sv
